@@ design/ps2fr_pkg.sv @@
package ps2fr_pkg;

    // Operation codes carried by an input word
    typedef enum logic [2:0] {
        OP_CLOCK_EDGE  = 3'd0,
        OP_TICK        = 3'd1,
        OP_GET_BYTE    = 3'd2,
        OP_GET_MESSAGE = 3'd3,
        OP_CLEAR       = 3'd4
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STATUS,
        ST_STREAM
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic exec;     // input word accepted this cycle
        logic stream;   // a message is being streamed out
        logic advance;  // current message byte taken
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic stream_ok;  // current word is a get message that will stream
        logic last_beat;  // streamed byte on the output is the final one
    } dp_status_t;

    localparam logic [7:0] TIMEOUT_RESET = 8'd25;
    localparam logic [8:0] IDLE_MAX      = 9'd511;
    localparam logic [3:0] POS_START     = 4'd0;
    localparam logic [3:0] POS_LAST_DATA = 4'd8;
    localparam logic [3:0] POS_PARITY    = 4'd9;
    localparam logic [3:0] POS_STOP      = 4'd10;

endpackage

@@ design/ps2fr_ctrl.sv @@
module ps2fr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  ps2fr_pkg::dp_status_t status,
    output ps2fr_pkg::ctrl_cmd_t  cmd
);
    import ps2fr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.exec    = 1'b0;
        cmd.stream  = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = status.stream_ok ? ST_STREAM : ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STREAM:
            begin
                out_valid  = 1'b1;
                cmd.stream = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    if (status.last_beat)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/ps2fr_datapath.sv @@
module ps2fr_datapath #(
    parameter int MESSAGE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [7:0]            cfg_write_data,
    input  logic [2:0]            operation,
    input  logic                  data_bit,
    input  logic [6:0]            request_limit,
    input  ps2fr_pkg::ctrl_cmd_t  cmd,
    output ps2fr_pkg::dp_status_t status,
    output logic [7:0]            data_byte,
    output logic                  data_valid,
    output logic                  byte_available,
    output logic                  frame_error,
    output logic                  message_ready,
    output logic [6:0]            message_length,
    output logic                  last_of_run
);
    import ps2fr_pkg::*;

    localparam int CNT_W = $clog2(MESSAGE_DEPTH + 1);
    localparam int IDX_W = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(MESSAGE_DEPTH);

    // Frame and message state
    logic [7:0]       timeout_reg;
    logic [3:0]       pos_reg,     pos_next;
    logic [7:0]       shift_reg,   shift_next;
    logic             parity_reg,  parity_next;
    logic [7:0]       held_reg,    held_next;
    logic             good_reg,    good_next;
    logic             fail_reg,    fail_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic             ready_reg,   ready_next;
    logic [8:0]       idle_reg,    idle_next;
    logic [7:0]       byte_reg,    byte_next;
    logic             valid_reg,   valid_next;
    logic [CNT_W-1:0] n_reg,       n_next;
    logic [CNT_W-1:0] idx_reg,     idx_next;
    logic [7:0]       rdata_reg;
    logic             mem_we;
    logic [7:0]       mem [0:MESSAGE_DEPTH-1];

    logic [6:0] count_ext;
    logic [6:0] take_len;
    logic [8:0] idle_inc;

    assign count_ext = 7'(count_reg);
    assign take_len  = (count_ext > request_limit) ? request_limit : count_ext;
    assign idle_inc  = (idle_reg < IDLE_MAX) ? idle_reg + 9'd1 : idle_reg;

    assign status.stream_ok = (operation == OP_GET_MESSAGE) && (request_limit != 7'd0)
                              && ready_reg && (count_reg != '0);
    assign status.last_beat = (idx_reg == n_reg - CNT_W'(1));

    // Operation decode and state update
    always_comb
    begin
        pos_next    = pos_reg;
        shift_next  = shift_reg;
        parity_next = parity_reg;
        held_next   = held_reg;
        good_next   = good_reg;
        fail_next   = fail_reg;
        count_next  = count_reg;
        ready_next  = ready_reg;
        idle_next   = idle_reg;
        byte_next   = byte_reg;
        valid_next  = valid_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        mem_we      = 1'b0;
        if (cmd.advance)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (cmd.exec)
        begin
            byte_next  = 8'd0;
            valid_next = 1'b0;
            case (operation)
                OP_CLOCK_EDGE:
                begin
                    if (pos_reg == POS_START)
                    begin
                        shift_next  = 8'd0;
                        parity_next = 1'b0;
                        if (data_bit)
                        begin
                            fail_next = 1'b1;
                            good_next = 1'b0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 4'd1;
                        end
                    end
                    else if (pos_reg <= POS_LAST_DATA)
                    begin
                        shift_next[3'(pos_reg - 4'd1)] = shift_reg[3'(pos_reg - 4'd1)]
                                                         | data_bit;
                        pos_next = pos_reg + 4'd1;
                    end
                    else if (pos_reg == POS_PARITY)
                    begin
                        parity_next = data_bit;
                        pos_next    = pos_reg + 4'd1;
                    end
                    else
                    begin
                        // stop bit, or an unused position
                        pos_next    = POS_START;
                        shift_next  = 8'd0;
                        parity_next = 1'b0;
                        if (pos_reg == POS_STOP && data_bit && (^{shift_reg, parity_reg}))
                        begin
                            held_next = shift_reg;
                            good_next = 1'b1;
                            fail_next = 1'b0;
                            if (count_reg < DEPTH_CNT)
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                idle_next  = 9'd0;
                                ready_next = 1'b0;
                            end
                            else
                            begin
                                fail_next = 1'b1;
                            end
                        end
                        else
                        begin
                            fail_next = 1'b1;
                            good_next = 1'b0;
                        end
                    end
                end
                OP_TICK:
                begin
                    idle_next = idle_inc;
                    if ((count_reg != '0) && (idle_inc > {1'b0, timeout_reg}))
                    begin
                        ready_next = 1'b1;
                    end
                end
                OP_GET_BYTE:
                begin
                    valid_next = good_reg;
                    byte_next  = good_reg ? held_reg : 8'd0;
                    good_next  = 1'b0;
                end
                OP_GET_MESSAGE:
                begin
                    if ((request_limit != 7'd0) && ready_reg)
                    begin
                        n_next     = CNT_W'(take_len);
                        idx_next   = '0;
                        count_next = '0;
                        ready_next = 1'b0;
                        idle_next  = 9'd0;
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                    ready_next = 1'b0;
                    idle_next  = 9'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            pos_reg     <= POS_START;
            shift_reg   <= 8'd0;
            parity_reg  <= 1'b0;
            held_reg    <= 8'd0;
            good_reg    <= 1'b0;
            fail_reg    <= 1'b0;
            count_reg   <= '0;
            ready_reg   <= 1'b0;
            idle_reg    <= 9'd0;
            valid_reg   <= 1'b0;
            n_reg       <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                timeout_reg <= cfg_write_data;
            end
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            parity_reg <= parity_next;
            held_reg   <= held_next;
            good_reg   <= good_next;
            fail_reg   <= fail_next;
            count_reg  <= count_next;
            ready_reg  <= ready_next;
            idle_reg   <= idle_next;
            valid_reg  <= valid_next;
            n_reg      <= n_next;
            idx_reg    <= idx_next;
        end
    end

    // Result byte for status words
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // Message store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= shift_reg;
        end
        rdata_reg <= mem[idx_next[IDX_W-1:0]];
    end

    // Result word
    assign data_byte      = cmd.stream ? rdata_reg : byte_reg;
    assign data_valid     = cmd.stream ? 1'b1 : valid_reg;
    assign byte_available = good_reg;
    assign frame_error    = fail_reg;
    assign message_ready  = ready_reg;
    assign message_length = cmd.stream ? 7'(n_reg) : count_ext;
    assign last_of_run    = cmd.stream ? status.last_beat : 1'b1;

endmodule

@@ design/ps2_frame_receiver.sv @@
// PS/2 frame receiver. Each input word is one event: a falling clock edge with
// the sampled data bit, a millisecond tick, a get-byte request, a get-message
// request or a clear. Frames are 11 bits (start 0, eight data bits LSB first,
// odd parity, stop 1); good bytes are latched for get byte and appended to a
// message store of MESSAGE_DEPTH bytes. The block handles one word at a time:
// a word is taken in one cycle and its status result is offered in the next.
// An accepted get message streams min(bytes held, request_limit) bytes, one
// per cycle while out_ready is high, read from the single read port of the
// store. The timeout register may only be written while no word is in flight.
module ps2_frame_receiver #(
    parameter int MESSAGE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] operation,
    input  logic       data_bit,
    input  logic [6:0] request_limit,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       data_valid,
    output logic       byte_available,
    output logic       frame_error,
    output logic       message_ready,
    output logic [6:0] message_length,
    output logic       last_of_run
);
    import ps2fr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ps2fr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ps2fr_datapath #(
        .MESSAGE_DEPTH (MESSAGE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .operation      (operation),
        .data_bit       (data_bit),
        .request_limit  (request_limit),
        .cmd            (cmd),
        .status         (status),
        .data_byte      (data_byte),
        .data_valid     (data_valid),
        .byte_available (byte_available),
        .frame_error    (frame_error),
        .message_ready  (message_ready),
        .message_length (message_length),
        .last_of_run    (last_of_run)
    );

endmodule

@@ design/ps2fr_checker.sv @@
module ps2fr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] data_byte,
    input logic       data_valid,
    input logic       last_of_run
);

    // One word in flight: never taking input while a result is shown
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    // A streamed message keeps going until its last byte
    a_stream_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid && data_valid)
        else $error("message stream broke off before its last byte");

    // The last word of a run frees the block
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_of_run |=> !out_valid && in_ready)
        else $error("block not idle after last word of a run");

    // A stalled result holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(last_of_run))
        else $error("stalled result changed");

    // No byte shown without its valid flag
    a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_valid |-> data_byte == 8'd0)
        else $error("byte value present without data_valid");

endmodule

bind ps2_frame_receiver ps2fr_checker u_checker (.*);
